// File: hw/rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 32;
	localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;

	localparam int COL_W   = 8;                       // screen_width field
	localparam int ROW_W   = 6;                       // screen_height field
	localparam int ATTR_W  = 8;
	localparam int CHAR_W  = 8;
	localparam int CELL_W  = ATTR_W + CHAR_W;
	localparam int ADDR_W  = $clog2(STORE_CELLS);     // cell index / cursor
	localparam int CNT_W   = ADDR_W + 1;              // holds the cell count itself
	localparam int REM_W   = $clog2(MAX_COLUMNS);     // remainder of cursor / width
	localparam int BIT_W   = $clog2(ADDR_W);          // divider step counter

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;

	localparam logic [COL_W-1:0]  WIDTH_RESET  = 8'd80;
	localparam logic [ROW_W-1:0]  HEIGHT_RESET = 6'd25;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_ATTR   = 2'd2
	} reg_idx_t;

	// Screen geometry as seen by the sequencer, derived from the registers.
	typedef struct packed {
		logic [COL_W-1:0]  width;      // 1..MAX_COLUMNS
		logic [CNT_W-1:0]  total;      // width * height
		logic [ADDR_W-1:0] last_row;   // start of the bottom row
		logic [ADDR_W-1:0] last_cell;  // total - 1
		logic [ATTR_W-1:0] attr;
	} geom_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} mem_wr_t;

endpackage

// File: hw/rtl/tcw_if.sv
// Request and result channels of the text console writer.
// Depends on tcw_pkg for field widths.
interface tcw_req_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [CHAR_W-1:0] char_code;
	logic [ADDR_W-1:0] cell_index;

	modport source(output valid, req_type, char_code, cell_index, input ready);
	modport sink(input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] cursor_pos;
	logic [CELL_W-1:0] cell_data;
	logic              scrolled;

	modport source(output valid, cursor_pos, cell_data, scrolled, input ready);
	modport sink(input valid, cursor_pos, cell_data, scrolled, output ready);
endinterface

// File: hw/rtl/tcw_regs.sv
// APB configuration registers and the screen geometry derived from them.
// Depends on tcw_pkg.
module tcw_regs
	import tcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output geom_t                 geom
);

	logic [COL_W-1:0]  width_q;
	logic [ROW_W-1:0]  height_q;
	logic [ATTR_W-1:0] attr_q;
	logic [COL_W-1:0]  w_eff;
	logic [ROW_W-1:0]  h_eff;
	logic [COL_W+ROW_W-1:0] prod;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			attr_q   <= ATTR_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_WIDTH:  width_q  <= pwdata[COL_W-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				REG_ATTR:   attr_q   <= pwdata[ATTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_HEIGHT: prdata = APB_DATA_W'(height_q);
			REG_ATTR:   prdata = APB_DATA_W'(attr_q);
			default:    prdata = '0;
		endcase
	end

	// saturate the geometry to the store's shape
	always_comb begin
		priority if (width_q == '0)
			w_eff = COL_W'(1);
		else if (width_q > COL_W'(MAX_COLUMNS))
			w_eff = COL_W'(MAX_COLUMNS);
		else
			w_eff = width_q;

		priority if (height_q == '0)
			h_eff = ROW_W'(1);
		else if (height_q > ROW_W'(MAX_ROWS))
			h_eff = ROW_W'(MAX_ROWS);
		else
			h_eff = height_q;
	end

	assign prod           = w_eff * h_eff;
	assign geom.width     = w_eff;
	assign geom.total     = prod[CNT_W-1:0];
	assign geom.last_row  = ADDR_W'(prod[CNT_W-1:0] - CNT_W'(w_eff));
	assign geom.last_cell = ADDR_W'(prod[CNT_W-1:0] - CNT_W'(1));
	assign geom.attr      = attr_q;

endmodule

// File: hw/rtl/tcw_store.sv
// Screen cell store: one write port, one read port with registered data.
// Depends on tcw_pkg.
module tcw_store
	import tcw_pkg::*;
(
	input  logic              clk,
	input  mem_wr_t           wr,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] cells [STORE_CELLS];

	always_ff @(posedge clk) begin
		if (wr.we)
			cells[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		rdata <= cells[raddr];
	end

endmodule

// File: hw/rtl/tcw_ctrl.sv
// Sequencer of the text console writer with its shared add/subtract unit:
// cursor division, placement compare, scroll copy, clear and reset sweeps.
// Depends on tcw_pkg and the tcw_req_if / tcw_rsp_if interfaces.
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  geom_t             geom,
	tcw_req_if.sink           req,
	tcw_rsp_if.source         rsp,
	output mem_wr_t           mem_wr,
	output logic [ADDR_W-1:0] mem_raddr,
	input  logic [CELL_W-1:0] mem_rdata
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_PUT,
		ST_INC,
		ST_DIV,
		ST_NL_SUB,
		ST_NL_ADD,
		ST_PLACE,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SW_ZERO,
		SW_CLEAR,
		SW_SCROLL
	} sweep_t;

	state_t            state_q;
	sweep_t            mode_q;
	logic [ADDR_W-1:0] cur_q;
	logic [CNT_W-1:0]  pos_q;
	logic [REM_W-1:0]  rem_q;
	logic [BIT_W-1:0]  bit_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] last_q;
	logic [CHAR_W-1:0] chr_q;
	logic [ADDR_W-1:0] idx_q;
	logic [CELL_W-1:0] data_q;
	logic              scr_q;

	logic              wr_vld_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              wr_copy_s1;

	logic              out_vld_q;
	logic [ADDR_W-1:0] out_cur_q;
	logic [CELL_W-1:0] out_data_q;
	logic              out_scr_q;

	// shared add/subtract unit
	logic [CNT_W-1:0]  alu_a;
	logic [CNT_W-1:0]  alu_b;
	logic              alu_sub;
	logic [CNT_W:0]    alu_y;
	logic              alu_lt;

	logic [CELL_W-1:0] fill_cell;
	logic              out_load;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			ST_DIV: begin
				alu_a = CNT_W'({rem_q, cur_q[bit_q]});
				alu_b = CNT_W'(geom.width);
			end
			ST_NL_SUB: begin
				alu_a = CNT_W'(cur_q);
				alu_b = CNT_W'(rem_q);
			end
			ST_NL_ADD: begin
				alu_a   = pos_q;
				alu_b   = CNT_W'(geom.width);
				alu_sub = 1'b0;
			end
			ST_PUT: begin
				alu_a = CNT_W'(cur_q);
				alu_b = geom.total;
			end
			ST_INC: begin
				alu_a   = CNT_W'(cur_q);
				alu_b   = CNT_W'(1);
				alu_sub = 1'b0;
			end
			ST_PLACE: begin
				alu_a = pos_q;
				alu_b = geom.total;
			end
			ST_SWEEP: begin
				alu_a = CNT_W'(cnt_q);
				alu_b = CNT_W'(geom.last_row);
			end
			default: ;
		endcase
	end

	assign alu_y  = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                        : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_lt = alu_y[CNT_W];

	assign fill_cell = (mode_q == SW_ZERO) ? '0 : {geom.attr, BLANK_CODE};

	// store ports: the put write and the sweep write never overlap
	always_comb begin
		if (state_q == ST_PUT) begin
			mem_wr.we   = alu_lt;
			mem_wr.addr = cur_q;
			mem_wr.data = {geom.attr, chr_q};
		end else begin
			mem_wr.we   = wr_vld_s1;
			mem_wr.addr = wr_addr_s1;
			mem_wr.data = wr_copy_s1 ? mem_rdata : fill_cell;
		end
	end

	assign mem_raddr = (state_q == ST_SWEEP) ? (cnt_q + ADDR_W'(geom.width)) : idx_q;

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_vld_q;
	assign rsp.cursor_pos = out_cur_q;
	assign rsp.cell_data  = out_data_q;
	assign rsp.scrolled   = out_scr_q;

	assign out_load = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			mode_q     <= SW_ZERO;
			cur_q      <= '0;
			pos_q      <= '0;
			rem_q      <= '0;
			bit_q      <= '0;
			cnt_q      <= '0;
			last_q     <= ADDR_W'(STORE_CELLS - 1);
			chr_q      <= '0;
			idx_q      <= '0;
			data_q     <= '0;
			scr_q      <= 1'b0;
			wr_vld_s1  <= 1'b0;
			wr_addr_s1 <= '0;
			wr_copy_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
			out_cur_q  <= '0;
			out_data_q <= '0;
			out_scr_q  <= 1'b0;
		end else begin
			wr_vld_s1 <= (state_q == ST_SWEEP || state_q == ST_INIT);
			if (state_q == ST_SWEEP || state_q == ST_INIT) begin
				wr_addr_s1 <= cnt_q;
				wr_copy_s1 <= (mode_q == SW_SCROLL) && alu_lt;
			end

			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_cur_q  <= cur_q;
				out_data_q <= data_q;
				out_scr_q  <= scr_q;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_INIT, ST_SWEEP: begin
					if (cnt_q == last_q)
						state_q <= ST_DRAIN;
					else
						cnt_q <= cnt_q + ADDR_W'(1);
				end
				ST_IDLE: begin
					if (req.valid) begin
						chr_q  <= req.char_code;
						idx_q  <= req.cell_index;
						data_q <= '0;
						scr_q  <= 1'b0;
						unique case (req.req_type)
							REQ_PUT: begin
								if (req.char_code == NEWLINE_CODE) begin
									rem_q   <= '0;
									bit_q   <= BIT_W'(ADDR_W - 1);
									state_q <= ST_DIV;
								end else begin
									state_q <= ST_PUT;
								end
							end
							REQ_READ: state_q <= ST_RD_ADDR;
							REQ_CLEAR: begin
								mode_q  <= SW_CLEAR;
								cnt_q   <= '0;
								last_q  <= geom.last_cell;
								state_q <= ST_SWEEP;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD_ADDR: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					data_q  <= mem_rdata;
					state_q <= ST_DONE;
				end
				ST_PUT: state_q <= ST_INC;
				ST_INC: begin
					pos_q   <= alu_y[CNT_W-1:0];
					state_q <= ST_PLACE;
				end
				ST_DIV: begin
					// one restoring step of cursor / width; keep the remainder only
					rem_q <= alu_lt ? alu_a[REM_W-1:0] : alu_y[REM_W-1:0];
					if (bit_q == '0)
						state_q <= ST_NL_SUB;
					else
						bit_q <= bit_q - BIT_W'(1);
				end
				ST_NL_SUB: begin
					pos_q   <= alu_y[CNT_W-1:0];
					state_q <= ST_NL_ADD;
				end
				ST_NL_ADD: begin
					pos_q   <= alu_y[CNT_W-1:0];
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					if (alu_lt) begin
						cur_q   <= pos_q[ADDR_W-1:0];
						state_q <= ST_DONE;
					end else begin
						scr_q   <= 1'b1;
						mode_q  <= SW_SCROLL;
						cnt_q   <= '0;
						last_q  <= geom.last_cell;
						state_q <= ST_SWEEP;
					end
				end
				ST_DRAIN: begin
					unique case (mode_q)
						SW_SCROLL: begin
							cur_q   <= geom.last_row;
							state_q <= ST_DONE;
						end
						SW_CLEAR: begin
							cur_q   <= '0;
							state_q <= ST_DONE;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/text_console_writer.sv
// Text console writer, built round a shared add/subtract unit and the single store
// write port. A scroll and a clear each sweep the cells of the screen, and one
// request is in work at a time. After reset the store is zeroed in a pass over
// all its cells; no request is taken meanwhile, while configuration writes are
// taken as ever.
module text_console_writer
	import tcw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	tcw_req_if.sink               req,
	tcw_rsp_if.source             rsp
);

	geom_t             geom;
	mem_wr_t           mem_wr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	tcw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	tcw_store u_store (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.req       (req),
		.rsp       (rsp),
		.mem_wr    (mem_wr),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// the store is written only while no request can be taken
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.we |-> !req.ready)
		else $error("store write while accepting requests");

	// an accepted beat keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("ready right after an accepted beat");

	// a scroll always leaves the cursor at the start of the bottom row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.scrolled) |-> (rsp.cursor_pos == geom.last_row))
		else $error("scrolled result with cursor off the bottom row");

endmodule

// File: dv/testbench.sv
// Self-checking bench for the text console writer: a directed script, then random phases
// of puts, newlines, reads and clears under changing geometry, attribute and flow control.
// Depends on tcw_pkg, the tcw_req_if / tcw_rsp_if channels and text_console_writer.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;   // no operation behind this code
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [ADDR_W-1:0] cursor_pos;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} console_status_t;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		reg_idx_t              sel;
		logic [APB_DATA_W-1:0] val;
		logic [1:0]            op;
		logic [CHAR_W-1:0]     chr;
		logic [ADDR_W-1:0]     idx;
		bit                    typed;
		console_status_t       want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tcw_req_if req_ch();
	tcw_rsp_if rsp_ch();

	text_console_writer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	always #1 clk = ~clk;

	// Shadow copy of the console: screen, cursor and registers.
	logic [CELL_W-1:0] shadow_cells [STORE_CELLS];
	int unsigned       shadow_cursor;
	logic [COL_W-1:0]  shadow_width;
	logic [ROW_W-1:0]  shadow_height;
	logic [ATTR_W-1:0] shadow_attr;

	console_status_t awaited_status[$];
	script_row_t     script[$];
	int              mismatches = 0;
	int              src_idle_pct = 0;
	int              snk_stall_pct = 0;
	bit              hold_kick = 1'b0;
	bit              hold_seen = 1'b0;
	int              hold_left = 0;

	function automatic int unsigned cols_now();
		if (shadow_width == 0) return 1;
		if (shadow_width > MAX_COLUMNS) return MAX_COLUMNS;
		return 32'(shadow_width);
	endfunction

	function automatic int unsigned rows_now();
		if (shadow_height == 0) return 1;
		if (shadow_height > MAX_ROWS) return MAX_ROWS;
		return 32'(shadow_height);
	endfunction

	// Move the cursor; past the last cell, shift the screen up a row and blank the bottom.
	function automatic bit seat_cursor(int unsigned pos);
		int unsigned w;
		int unsigned total;
		w = cols_now();
		total = w * rows_now();
		if (pos < total) begin
			shadow_cursor = pos;
			return 1'b0;
		end
		for (int unsigned i = 0; i + w < total; i++)
			shadow_cells[i] = shadow_cells[i + w];
		for (int unsigned i = total - w; i < total; i++)
			shadow_cells[i] = {shadow_attr, BLANK_CODE};
		shadow_cursor = total - w;
		return 1'b1;
	endfunction

	function automatic console_status_t console_apply(logic [1:0] op, logic [CHAR_W-1:0] chr,
			logic [ADDR_W-1:0] idx);
		int unsigned w;
		int unsigned total;
		console_status_t st;
		w = cols_now();
		total = w * rows_now();
		st = '0;
		case (op)
		REQ_PUT: begin
			if (chr == NEWLINE_CODE) begin
				st.scrolled = seat_cursor((shadow_cursor / w + 1) * w);
			end else begin
				// a cursor left beyond a shrunken screen writes nothing
				if (shadow_cursor < total)
					shadow_cells[shadow_cursor] = {shadow_attr, chr};
				st.scrolled = seat_cursor(shadow_cursor + 1);
			end
		end
		REQ_READ: begin
			st.cell_data = shadow_cells[idx];
		end
		REQ_CLEAR: begin
			for (int unsigned i = 0; i < total; i++)
				shadow_cells[i] = {shadow_attr, BLANK_CODE};
			shadow_cursor = 0;
		end
		default: begin
		end
		endcase
		st.cursor_pos = shadow_cursor[ADDR_W-1:0];
		return st;
	endfunction

	function automatic script_row_t cfg_row(reg_idx_t sel, logic [APB_DATA_W-1:0] val);
		script_row_t r;
		r.kind = ROW_CFG;
		r.sel = sel;
		r.val = val;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic script_row_t req_row(logic [1:0] op, logic [CHAR_W-1:0] chr,
			logic [ADDR_W-1:0] idx);
		script_row_t r;
		r.kind = ROW_REQ;
		r.op = op;
		r.chr = chr;
		r.idx = idx;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic script_row_t fixed_row(logic [1:0] op, logic [CHAR_W-1:0] chr,
			logic [ADDR_W-1:0] idx, logic [ADDR_W-1:0] cursor, logic [CELL_W-1:0] cell_val,
			logic scr);
		script_row_t r;
		r = req_row(op, chr, idx);
		r.typed = 1'b1;
		r.want = {cursor, cell_val, scr};
		return r;
	endfunction

	// Offer one request beat; hold it until taken, then log what should come back.
	task automatic offer_request(logic [1:0] op, logic [CHAR_W-1:0] chr,
			logic [ADDR_W-1:0] idx, bit typed, console_status_t want);
		console_status_t st;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= op;
		req_ch.char_code <= chr;
		req_ch.cell_index <= idx;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		st = console_apply(op, chr, idx);
		awaited_status.push_back(typed ? want : st);
	endtask

	// Register write once every outstanding result is back.
	task automatic write_reg(reg_idx_t sel, logic [APB_DATA_W-1:0] val);
		req_ch.valid <= 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (sel)
		REG_WIDTH: begin
			shadow_width = val[COL_W-1:0];
		end
		REG_HEIGHT: begin
			shadow_height = val[ROW_W-1:0];
		end
		REG_ATTR: begin
			shadow_attr = val[ATTR_W-1:0];
		end
		default: begin
		end
		endcase
		@(posedge clk);
	endtask

	task automatic random_request();
		int unsigned pick;
		int unsigned total;
		logic [1:0] op;
		logic [CHAR_W-1:0] chr;
		logic [ADDR_W-1:0] idx;
		console_status_t no_want;
		total = cols_now() * rows_now();
		pick = $urandom_range(99);
		chr = CHAR_W'($urandom_range(255));
		idx = ADDR_W'($urandom_range(STORE_CELLS - 1));
		no_want = '0;
		op = REQ_PUT;
		if (pick < 60) begin
			op = REQ_PUT;
		end else if (pick < 80) begin
			chr = NEWLINE_CODE;
		end else if (pick < 93) begin
			op = REQ_READ;
			// bias half the reads onto the visible screen
			if (pick[0])
				idx = ADDR_W'($urandom_range(total - 1));
		end else if (pick < 97) begin
			op = REQ_CLEAR;
		end else begin
			op = REQ_UNUSED;
		end
		offer_request(op, chr, idx, 1'b0, no_want);
	endtask

	always @(posedge clk) begin : collect_status
		console_status_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_status.size() == 0) begin
				$display("%0t: unexpected result beat: cursor %0d cell %h scrolled %0d",
					$time, rsp_ch.cursor_pos, rsp_ch.cell_data, rsp_ch.scrolled);
				mismatches++;
			end else begin
				want = awaited_status.pop_front();
				if (rsp_ch.cursor_pos !== want.cursor_pos) begin
					$display("%0t: cursor_pos expected %0d actual %0d",
						$time, want.cursor_pos, rsp_ch.cursor_pos);
					mismatches++;
				end
				if (rsp_ch.cell_data !== want.cell_data) begin
					$display("%0t: cell_data expected %h actual %h",
						$time, want.cell_data, rsp_ch.cell_data);
					mismatches++;
				end
				if (rsp_ch.scrolled !== want.scrolled) begin
					$display("%0t: scrolled expected %0d actual %0d",
						$time, want.scrolled, rsp_ch.scrolled);
					mismatches++;
				end
			end
		end
		// long hold-off on request, otherwise random stalls
		if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		int unsigned cols;
		int unsigned rows;
		logic [ATTR_W-1:0] attr;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.char_code = '0;
		req_ch.cell_index = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < STORE_CELLS; i++)
			shadow_cells[i] = '0;
		shadow_cursor = 0;
		shadow_width = WIDTH_RESET;
		shadow_height = HEIGHT_RESET;
		shadow_attr = ATTR_RESET;

		// Reset state, field extremes, every operation, tiny and oversized screens,
		// and a cursor left beyond a screen that was made smaller.
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd0, 12'd0, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_READ, 8'hFF, 12'd4095, 12'd0, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_PUT, 8'h41, 12'd0, 12'd1, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_PUT, 8'h00, 12'hFFF, 12'd2, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_PUT, 8'hFF, 12'd0, 12'd3, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd2, 12'd3, 16'h07FF, 1'b0));
		script.push_back(fixed_row(REQ_PUT, NEWLINE_CODE, 12'd0, 12'd80, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_UNUSED, 8'hFF, 12'hFFF, 12'd80, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_CLEAR, 8'h00, 12'd0, 12'd0, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd1999, 12'd0, 16'h0720, 1'b0));
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd2000, 12'd0, 16'h0000, 1'b0));
		script.push_back(cfg_row(REG_ATTR, 32'hFF));
		script.push_back(cfg_row(REG_WIDTH, 32'd0));
		script.push_back(cfg_row(REG_HEIGHT, 32'd0));
		script.push_back(fixed_row(REQ_PUT, 8'h5A, 12'd0, 12'd0, 16'h0000, 1'b1));
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd0, 12'd0, 16'hFF20, 1'b0));
		script.push_back(fixed_row(REQ_PUT, NEWLINE_CODE, 12'd0, 12'd0, 16'h0000, 1'b1));
		script.push_back(cfg_row(REG_WIDTH, 32'd255));
		script.push_back(cfg_row(REG_HEIGHT, 32'd63));
		script.push_back(cfg_row(REG_ATTR, 32'h00));
		script.push_back(fixed_row(REQ_PUT, 8'h80, 12'd0, 12'd1, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd0, 12'd1, 16'h0080, 1'b0));
		script.push_back(fixed_row(REQ_CLEAR, 8'hFF, 12'hFFF, 12'd0, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd4095, 12'd0, 16'h0020, 1'b0));
		script.push_back(fixed_row(REQ_PUT, NEWLINE_CODE, 12'd0, 12'd128, 16'h0000, 1'b0));
		script.push_back(fixed_row(REQ_PUT, NEWLINE_CODE, 12'd0, 12'd256, 16'h0000, 1'b0));
		script.push_back(cfg_row(REG_WIDTH, 32'd4));
		script.push_back(cfg_row(REG_HEIGHT, 32'd2));
		script.push_back(fixed_row(REQ_PUT, 8'h33, 12'd0, 12'd4, 16'h0000, 1'b1));
		script.push_back(fixed_row(REQ_READ, 8'h00, 12'd256, 12'd4, 16'h0020, 1'b0));
		script.push_back(req_row(REQ_READ, 8'h00, 12'd0));
		script.push_back(req_row(REQ_PUT, 8'h7E, 12'd0));
		script.push_back(fixed_row(REQ_PUT, NEWLINE_CODE, 12'd0, 12'd4, 16'h0000, 1'b1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				write_reg(script[i].sel, script[i].val);
			else
				offer_request(script[i].op, script[i].chr, script[i].idx, script[i].typed,
					script[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
			0: begin
				src_idle_pct = 0;
				snk_stall_pct <= 0;
			end
			1: begin
				src_idle_pct = 52;
				snk_stall_pct <= 0;
			end
			2: begin
				src_idle_pct = 0;
				snk_stall_pct <= 52;
			end
			default: begin
				src_idle_pct = 18;
				snk_stall_pct <= 18;
			end
			endcase
			case (p % 6)
			0: begin
				cols = $urandom_range(1, 16);
				rows = $urandom_range(1, 8);
			end
			1: begin
				cols = 1;
				rows = $urandom_range(1, 32);
			end
			2: begin
				cols = $urandom_range(1, 128);
				rows = 1;
			end
			3: begin
				cols = 128;
				rows = 32;
			end
			4: begin
				// out-of-range values saturate to the limits
				cols = $urandom_range(1) ? 0 : $urandom_range(129, 255);
				rows = $urandom_range(1) ? 0 : $urandom_range(33, 63);
			end
			default: begin
				cols = $urandom_range(2, 40);
				rows = $urandom_range(2, 12);
			end
			endcase
			case (p % 4)
			0: attr = 8'hFF;
			1: attr = 8'h00;
			default: attr = ATTR_W'($urandom_range(255));
			endcase
			write_reg(REG_WIDTH, cols);
			write_reg(REG_HEIGHT, rows);
			write_reg(REG_ATTR, APB_DATA_W'(attr));
			if (p == 2 || p == 9)
				hold_kick <= ~hold_kick;
			repeat (ITEMS_PER_PHASE) random_request();
		end

		req_ch.valid <= 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0 && awaited_status.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(100_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
